// File: design/rmt_pkg.sv
package rmt_pkg;

	localparam int SAMPLE_W = 32;
	localparam int KEPT_W   = 7;

endpackage

// File: design/rmt_if.sv
interface rmt_in_if
	import rmt_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (output valid, sample, last_sample, input ready);
	modport sink (input valid, sample, last_sample, output ready);
endinterface

interface rmt_out_if
	import rmt_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] median;
	logic [KEPT_W-1:0]          kept_count;
	logic                       overflow;

	modport source (output valid, median, kept_count, overflow, input ready);
	modport sink (input valid, median, kept_count, overflow, output ready);
endinterface

// File: design/rmt_store.sv
module rmt_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: design/running_median_tracker_unit.sv
// Running lower median over a sample sequence. Kept samples sit in ascending
// order in a single-port-write, one-read memory of CAPACITY entries. A sample
// into an empty store is written straight to entry zero; into a full store it
// is dropped and overflow is flagged. Otherwise the insertion walks the store
// down from its top entry, one read and one shifted write per cycle, then one
// read fetches the median. A held result does not block the next sample from
// being taken, but a second result waits until the first is accepted.
// last_sample empties the store after its result.
module running_median_tracker_unit
	import rmt_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	rmt_in_if.sink    feed,
	rmt_out_if.source report
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PUT0, S_MEDRD, S_MEDWT} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         j_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic                  last_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   median_q;
	logic [KEPT_W-1:0]     kept_q;
	logic                  out_ovf_q;

	logic [DATA_WIDTH-1:0] x_in;
	logic [SAMPLE_W-1:0]   med_val;
	logic                  we, re;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         mid;
	logic                  take;
	logic                  shift_up;

	generate
		if (DATA_WIDTH >= SAMPLE_W) begin : g_wide
			assign x_in    = DATA_WIDTH'(feed.sample);
			assign med_val = rdata[SAMPLE_W-1:0];
		end else begin : g_narrow
			assign x_in    = feed.sample[DATA_WIDTH-1:0];
			assign med_val = SAMPLE_W'($signed(rdata));
		end
	endgenerate

	assign take     = feed.valid && feed.ready;
	assign cnt_m1   = cnt_q - CW'(1);
	assign mid      = cnt_m1 >> 1;
	assign shift_up = $signed(rdata) > $signed(x_q);

	assign feed.ready        = (state_q == S_IDLE);
	assign report.valid      = out_valid_q;
	assign report.median     = median_q;
	assign report.kept_count = kept_q;
	assign report.overflow   = out_ovf_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		wdata = x_q;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (take && cnt_q == '0) begin
					we    = 1'b1;
					wdata = x_in;
				end else if (take && cnt_q != CW'(CAPACITY)) begin
					re    = 1'b1;
					raddr = cnt_m1[AW-1:0];
				end
			end
			S_SCAN: begin
				we    = 1'b1;
				waddr = j_q;
				if (shift_up) begin
					wdata = rdata;
					if (j_q != AW'(1)) begin
						re    = 1'b1;
						raddr = j_q - AW'(2);
					end
				end
			end
			S_PUT0: begin
				we = 1'b1;
			end
			S_MEDRD: begin
				re    = 1'b1;
				raddr = mid[AW-1:0];
			end
			default: ;
		endcase
	end

	rmt_store #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			last_q      <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			// in S_MEDWT the result register is reloaded below
			if (out_valid_q && report.ready && state_q != S_MEDWT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						x_q    <= x_in;
						last_q <= feed.last_sample;
						if (cnt_q == CW'(CAPACITY)) begin
							ovf_q   <= 1'b1;
							state_q <= S_MEDRD;
						end else if (cnt_q == '0) begin
							ovf_q   <= 1'b0;
							cnt_q   <= CW'(1);
							state_q <= S_MEDRD;
						end else begin
							ovf_q   <= 1'b0;
							j_q     <= cnt_q[AW-1:0];
							cnt_q   <= cnt_q + CW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (!shift_up) begin
						state_q <= S_MEDRD;
					end else if (j_q == AW'(1)) begin
						state_q <= S_PUT0;
					end else begin
						j_q <= j_q - AW'(1);
					end
				end
				S_PUT0: state_q <= S_MEDRD;
				S_MEDRD: state_q <= S_MEDWT;
				S_MEDWT: begin
					if (!out_valid_q || report.ready) begin
						out_valid_q <= 1'b1;
						median_q    <= med_val;
						kept_q      <= KEPT_W'(cnt_q);
						out_ovf_q   <= ovf_q;
						if (last_q) begin
							cnt_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("held count exceeds capacity");

	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> j_q != '0)
		else $error("scan reached entry zero");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cnt_q == CW'(CAPACITY)) |=> ovf_q && cnt_q == CW'(CAPACITY))
		else $error("dropped sample changed the count");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MEDWT && (!out_valid_q || report.ready) |=> out_valid_q)
		else $error("result not presented");
endmodule
